>>> rtl/rc5tx_pkg.sv
// Shared types and constants for the RC5 infrared frame transmitter.
// Depends on nothing; every other file of the block imports it.
package rc5tx_pkg;

    // Frame layout
    localparam int unsigned FRAME_BITS = 14;
    localparam int unsigned HALF_BITS  = 2 * FRAME_BITS;
    localparam int unsigned HALF_W     = $clog2(HALF_BITS);
    localparam int unsigned BIT_IDX_W  = $clog2(FRAME_BITS);
    localparam logic [HALF_W-1:0] HALF_LAST = HALF_W'(HALF_BITS - 1);
    localparam logic [BIT_IDX_W-1:0] BIT_TOP = BIT_IDX_W'(FRAME_BITS - 1);

    // Field and register widths
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned CMD_W   = 6;
    localparam int unsigned CARR_W  = 8;
    localparam int unsigned PULSE_W = 8;
    localparam int unsigned SPACE_W = 12;
    localparam int unsigned TICK_W  = 12;
    localparam int unsigned CFG_DATA_W = 12;

    // Register reset values
    localparam logic [CARR_W-1:0]  CARR_HIGH_RST = 8'd7;
    localparam logic [CARR_W-1:0]  CARR_LOW_RST  = 8'd21;
    localparam logic [PULSE_W-1:0] PULSES_RST    = 8'd32;
    localparam logic [SPACE_W-1:0] SPACE_RST     = 12'd889;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CARRIER_HIGH = 2'd0,
        CFG_CARRIER_LOW  = 2'd1,
        CFG_PULSES       = 2'd2,
        CFG_SPACE        = 2'd3
    } cfg_idx_t;

    // Input word
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [CMD_W-1:0]  command;
    } in_t;

    // Result word
    typedef struct packed {
        logic led;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } out_t;

    // Timing configuration seen by the engine
    typedef struct packed {
        logic [CARR_W-1:0]  carrier_high;
        logic [CARR_W-1:0]  carrier_low;
        logic [PULSE_W-1:0] pulses;
        logic [SPACE_W-1:0] space;
    } timing_t;

endpackage

>>> rtl/rc5_ir_frame_transmitter_core.sv
// Top level of the RC5 infrared frame transmitter.
// Depends on rc5tx_pkg, rc5tx_cfg_regs, rc5tx_in_stage and rc5tx_engine.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): each word is either a tick,
//   which advances the LED waveform by one time step, or a send request
//   carrying a 5-bit address and 6-bit command. A send while a frame is in
//   progress is dropped and reported with accepted = 0.
//   Output channel (out_valid/out_stall/out_data): exactly one result word
//   per input word: LED level, busy flag, accepted flag, frame_done flag.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): carrier high
//   and low ticks, pulses per half-bit and space ticks; cfg_ready is always
//   high. Write only while no word is in flight.
//   Each word passes through the input register, then the result register,
//   before out_valid rises. Throughput: one word per cycle while out_stall is low.
//   A stall on the output holds the result register; the input register
//   then fills and in_stall rises in the same cycle, so nothing is lost.
//   Reset: timing registers return to 7/21/32/889, the transmitter is idle
//   and the first frame after reset carries toggle bit one.
module rc5_ir_frame_transmitter_core
    import rc5tx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    timing_t timing;
    logic    item_valid;
    logic    item_take;
    in_t     item;

    // Timing registers
    rc5tx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    // Input register
    rc5tx_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Sequencer and result register
    rc5tx_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .timing     (timing),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> rtl/rc5tx_cfg_regs.sv
// Timing configuration registers of the RC5 transmitter.
// Depends on rc5tx_pkg.
module rc5tx_cfg_regs
    import rc5tx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output timing_t               timing
);

    timing_t timing_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register file, truncated to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.carrier_high <= CARR_HIGH_RST;
            timing_reg.carrier_low  <= CARR_LOW_RST;
            timing_reg.pulses       <= PULSES_RST;
            timing_reg.space        <= SPACE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CARRIER_HIGH: timing_reg.carrier_high <= cfg_data[CARR_W-1:0];
                CFG_CARRIER_LOW:  timing_reg.carrier_low  <= cfg_data[CARR_W-1:0];
                CFG_PULSES:       timing_reg.pulses       <= cfg_data[PULSE_W-1:0];
                CFG_SPACE:        timing_reg.space        <= cfg_data[SPACE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign timing = timing_reg;

endmodule

>>> rtl/rc5tx_in_stage.sv
// Input register of the RC5 transmitter: holds one word until the engine takes it.
// Depends on rc5tx_pkg.
module rc5tx_in_stage
    import rc5tx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    input  logic item_take,
    output logic item_valid,
    output in_t  item
);

    logic in_valid_reg;
    in_t  in_data_reg;

    // Stall only while a held word is not being taken
    assign in_stall = in_valid_reg && !item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_data_reg <= in_data;
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = in_data_reg;

endmodule

>>> rtl/rc5tx_engine.sv
// Frame state and Manchester / carrier sequencer of the RC5 transmitter,
// with the result register. Depends on rc5tx_pkg.
module rc5tx_engine
    import rc5tx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  timing_t timing,
    input  logic    item_valid,
    input  in_t     item,
    output logic    item_take,
    output logic    out_valid,
    input  logic    out_stall,
    output out_t    out_data
);

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [HALF_W-1:0]     half_reg, half_next;
    logic [PULSE_W-1:0]    pulse_reg, pulse_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic                  phase_reg, phase_next;
    logic                  toggle_reg, toggle_next;
    logic                  sending_reg, sending_next;
    logic                  out_valid_reg;
    out_t                  out_data_reg, out_data_next;

    logic                  cur_mark;
    logic [TICK_W-1:0]     tick_inc;
    logic [CARR_W-1:0]     carrier_limit;
    logic [PULSE_W-1:0]    pulse_inc;
    logic                  half_over;
    logic                  done;
    logic                  accepted;

    // Mark half-bit test: odd half of a one, even half of a zero
    function automatic logic half_is_mark(input logic [HALF_W-1:0] h,
                                          input logic [FRAME_BITS-1:0] f);
        logic [BIT_IDX_W-1:0] bit_idx;
        bit_idx = BIT_TOP - h[HALF_W-1:1];
        if (h > HALF_LAST)
            return 1'b0;
        return h[0] == f[bit_idx];
    endfunction

    // Result register advances when empty or being drained
    assign item_take = item_valid && (!out_valid_reg || !out_stall);

    // Next state and result for the held word
    always_comb
    begin
        frame_next   = frame_reg;
        half_next    = half_reg;
        pulse_next   = pulse_reg;
        tick_next    = tick_reg;
        phase_next   = phase_reg;
        toggle_next  = toggle_reg;
        sending_next = sending_reg;
        accepted     = 1'b0;
        done         = 1'b0;
        half_over    = 1'b0;
        cur_mark     = half_is_mark(half_reg, frame_reg);
        tick_inc     = tick_reg + TICK_W'(1);
        carrier_limit = phase_reg ? timing.carrier_high : timing.carrier_low;
        pulse_inc    = pulse_reg + PULSE_W'(1);

        if (item.kind == KIND_SEND)
        begin
            // New frame; first half-bit is always a space (start bit is one)
            if (!sending_reg)
            begin
                frame_next   = {2'b11, ~toggle_reg, item.address, item.command};
                toggle_next  = ~toggle_reg;
                sending_next = 1'b1;
                half_next    = '0;
                pulse_next   = '0;
                tick_next    = '0;
                phase_next   = 1'b0;
                accepted     = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            tick_next = tick_inc;
            if (cur_mark)
            begin
                // Carrier pulse timing
                if (tick_inc >= {{(TICK_W-CARR_W){1'b0}}, carrier_limit})
                begin
                    tick_next = '0;
                    if (phase_reg)
                    begin
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        pulse_next = pulse_inc;
                        if (pulse_inc >= timing.pulses)
                            half_over = 1'b1;
                        else
                            phase_next = 1'b1;
                    end
                end
            end
            else if (tick_inc >= timing.space)
            begin
                half_over = 1'b1;
            end

            // Move to the next half-bit or finish the frame
            if (half_over)
            begin
                pulse_next = '0;
                tick_next  = '0;
                if (half_reg == HALF_LAST)
                begin
                    sending_next = 1'b0;
                    half_next    = '0;
                    phase_next   = 1'b0;
                    done         = 1'b1;
                end
                else
                begin
                    half_next  = half_reg + HALF_W'(1);
                    phase_next = half_is_mark(half_reg + HALF_W'(1), frame_reg);
                end
            end
        end

        out_data_next.led        = sending_next && phase_next &&
                                   half_is_mark(half_next, frame_next);
        out_data_next.busy_res   = sending_next;
        out_data_next.accepted   = accepted;
        out_data_next.frame_done = done;
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            half_reg      <= '0;
            pulse_reg     <= '0;
            tick_reg      <= '0;
            phase_reg     <= 1'b0;
            toggle_reg    <= 1'b0;
            sending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                frame_reg   <= frame_next;
                half_reg    <= half_next;
                pulse_reg   <= pulse_next;
                tick_reg    <= tick_next;
                phase_reg   <= phase_next;
                toggle_reg  <= toggle_next;
                sending_reg <= sending_next;
            end
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.frame_done |-> !out_data_reg.busy_res)
        else $error("frame_done reported while still busy");

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.accepted |-> out_data_reg.busy_res)
        else $error("accepted frame not reported busy");

    a_half_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg <= HALF_LAST)
        else $error("half-bit index out of range");

    a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (half_reg == '0 && tick_reg == '0 && !phase_reg))
        else $error("sequencer state not cleared while idle");
`endif

endmodule

>>> sim/rc5_ir_frame_transmitter_core_tb.sv
// Self-checking testbench for the RC5 infrared frame transmitter core.
// Scoreboard tracks frame timing and LED level word by word; needs rc5tx_pkg and
// rc5_ir_frame_transmitter_core.
module rc5_ir_frame_transmitter_core_tb;

    import rc5tx_pkg::*;

    localparam int IDLE_MAX        = 3;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PHASES   = 3;
    localparam int WORDS_PER_PHASE = 100;

    // Expected LED waveform and flags, one result word per input word
    class rc5_frame_scoreboard;
        logic [CARR_W-1:0]     high_ticks;
        logic [CARR_W-1:0]     low_ticks;
        logic [PULSE_W-1:0]    pulses;
        logic [SPACE_W-1:0]    space_len;
        logic [FRAME_BITS-1:0] frame;
        logic [HALF_W-1:0]     half;
        logic [PULSE_W-1:0]    pulse_cnt;
        logic [TICK_W-1:0]     tick_cnt;
        logic                  carrier_on;
        logic                  toggle;
        logic                  busy;
        out_t                  pending[$];
        int                    errors;

        function new();
            high_ticks = CARR_HIGH_RST;
            low_ticks  = CARR_LOW_RST;
            pulses     = PULSES_RST;
            space_len  = SPACE_RST;
            frame      = '0;
            half       = '0;
            pulse_cnt  = '0;
            tick_cnt   = '0;
            carrier_on = 1'b0;
            toggle     = 1'b0;
            busy       = 1'b0;
            errors     = 0;
        endfunction

        // Register write, masked to the register width
        function void load_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CARRIER_HIGH: high_ticks = val[CARR_W-1:0];
                CFG_CARRIER_LOW:  low_ticks  = val[CARR_W-1:0];
                CFG_PULSES:       pulses     = val[PULSE_W-1:0];
                CFG_SPACE:        space_len  = val[SPACE_W-1:0];
                default: ;
            endcase
        endfunction

        // Manchester: a one is space then mark, a zero is mark then space
        function bit is_mark(logic [HALF_W-1:0] h);
            int unsigned pos;
            if (h >= HALF_BITS)
                return 1'b0;
            pos = FRAME_BITS - 1 - (h >> 1);
            return h[0] == frame[pos];
        endfunction

        function void enter_half(logic [HALF_W-1:0] h);
            half       = h;
            pulse_cnt  = '0;
            tick_cnt   = '0;
            carrier_on = is_mark(h);
        endfunction

        // One tick of the waveform; returns 1 when the last half-bit ends.
        // A zero register compares like a one here, as the block does.
        function bit step_tick();
            bit half_over;
            half_over = 1'b0;
            tick_cnt  = tick_cnt + 1'b1;
            if (is_mark(half))
            begin
                if (tick_cnt >= (carrier_on ? high_ticks : low_ticks))
                begin
                    tick_cnt = '0;
                    if (carrier_on)
                        carrier_on = 1'b0;
                    else
                    begin
                        pulse_cnt = pulse_cnt + 1'b1;
                        if (pulse_cnt >= pulses)
                            half_over = 1'b1;
                        else
                            carrier_on = 1'b1;
                    end
                end
            end
            else if (tick_cnt >= space_len)
                half_over = 1'b1;
            if (!half_over)
                return 1'b0;
            if (half == HALF_LAST)
            begin
                busy       = 1'b0;
                half       = '0;
                pulse_cnt  = '0;
                tick_cnt   = '0;
                carrier_on = 1'b0;
                return 1'b1;
            end
            enter_half(half + 1'b1);
            return 1'b0;
        endfunction

        // Accepted input word: update state and queue the expected result
        function void note_word(in_t w);
            out_t want;
            logic took;
            logic done;
            took = 1'b0;
            done = 1'b0;
            if (w.kind == KIND_SEND)
            begin
                // a send while busy is dropped
                if (!busy)
                begin
                    frame  = {2'b11, ~toggle, w.address, w.command};
                    toggle = ~toggle;
                    busy   = 1'b1;
                    enter_half('0);
                    took   = 1'b1;
                end
            end
            else if (busy)
                done = step_tick();
            want.led        = busy & is_mark(half) & carrier_on;
            want.busy_res   = busy;
            want.accepted   = took;
            want.frame_done = done;
            pending.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result word %b with nothing pending", got));
                return;
            end
            want = pending.pop_front();
            if (got.led !== want.led)
                report($sformatf("led %b, want %b", got.led, want.led));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
            if (got.accepted !== want.accepted)
                report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
            if (got.frame_done !== want.frame_done)
                report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rc5_frame_scoreboard sb = new();
    bit in_calm;
    bit out_calm;
    int stuck = 0;

    rc5_ir_frame_transmitter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Drive one input word after a random gap; returns with valid still high
    task automatic put_word(input in_t w);
        int gap;
        if ($urandom_range(0, 49) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(w);
    endtask

    task automatic push_tick();
        in_t w;
        w.kind    = KIND_TICK;
        w.address = ADDR_W'($urandom);
        w.command = CMD_W'($urandom);
        put_word(w);
    endtask

    task automatic push_ticks(input int count);
        repeat (count) push_tick();
    endtask

    task automatic push_send(input logic [ADDR_W-1:0] addr, input logic [CMD_W-1:0] cmd);
        in_t w;
        w.kind    = KIND_SEND;
        w.address = addr;
        w.command = cmd;
        put_word(w);
    endtask

    // Tick until the frame in progress has gone out
    task automatic drain_frame();
        while (sb.busy) push_tick();
    endtask

    // Idle the input and wait for every pending result
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.load_reg(idx, val);
    endtask

    // Write one timing register, then leave the config channel idle
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_beat(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write all four timing registers back to back
    task automatic program_timing(input logic [CFG_DATA_W-1:0] high_t,
                                  input logic [CFG_DATA_W-1:0] low_t,
                                  input logic [CFG_DATA_W-1:0] pulse_n,
                                  input logic [CFG_DATA_W-1:0] space_t);
        cfg_valid <= 1'b1;
        cfg_beat(CFG_CARRIER_HIGH, high_t);
        cfg_beat(CFG_CARRIER_LOW, low_t);
        cfg_beat(CFG_PULSES, pulse_n);
        cfg_beat(CFG_SPACE, space_t);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly ticks during a frame, frequent sends when idle
    task automatic random_phase();
        int     counted;
        in_t    w;
        counted = 0;
        while (counted < WORDS_PER_PHASE)
        begin
            w.address = ADDR_W'($urandom);
            w.command = CMD_W'($urandom);
            if (sb.busy)
                w.kind = ($urandom_range(0, 15) == 0) ? KIND_SEND : KIND_TICK;
            else
                w.kind = ($urandom_range(0, 1) == 0) ? KIND_SEND : KIND_TICK;
            // idle ticks and sends during a frame change nothing
            if ((w.kind == KIND_SEND) != sb.busy)
                counted++;
            put_word(w);
        end
        drain_frame();
        settle();
    endtask

    // Result side: random stall before each word
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                out_calm = !out_calm;
            gap = out_calm ? 0 : $urandom_range(0, IDLE_MAX);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_word(out_data);
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CARRIER_HIGH;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: idle ticks, send, send while busy, part of the 889-tick space
        push_tick();
        push_tick();
        push_send('1, '1);
        push_send('0, '0);
        push_ticks(40);
        settle();

        // short space ends the first half; the mark runs at the reset carrier
        write_reg(CFG_SPACE, 12'd1);
        push_ticks(100);
        settle();

        // fast carrier to finish the 32 reset pulses, then short timing to the end
        write_reg(CFG_CARRIER_HIGH, 12'd1);
        write_reg(CFG_CARRIER_LOW, 12'd1);
        push_ticks(70);
        settle();
        program_timing(12'd1, 12'd1, 12'd1, 12'd1);
        drain_frame();
        push_tick();
        settle();

        // zero registers behave as one
        program_timing('0, '0, '0, '0);
        push_send('0, '0);
        push_send(5'b10101, 6'b101010);
        drain_frame();
        push_send(5'b01010, 6'b010101);
        drain_frame();
        push_tick();
        settle();

        // values wider than the 8-bit registers are masked
        program_timing(12'hF02, 12'h001, 12'h103, 12'h002);
        push_send('1, '0);
        drain_frame();
        settle();

        // longest carrier high and low times over the first mark half-bits
        program_timing(12'd255, 12'd255, 12'd1, 12'd1);
        push_send(ADDR_W'($urandom), CMD_W'($urandom));
        push_ticks(520);
        settle();
        program_timing(12'd1, 12'd1, 12'd1, 12'd1);
        drain_frame();
        settle();

        // random traffic over short random timings
        repeat (RANDOM_PHASES)
        begin
            program_timing(CFG_DATA_W'($urandom_range(0, 3)),
                           CFG_DATA_W'($urandom_range(0, 3)),
                           CFG_DATA_W'($urandom_range(0, 3)),
                           CFG_DATA_W'($urandom_range(0, 6)));
            random_phase();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
